>>> rtl/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg: shared constants of the median by min/max elimination unit
// Sample width, store depth and the derived widths of counters and buses.
// ----------------------------------------------------------------------------
package mme_pkg;

    localparam int MAX_SAMPLES  = 16;
    localparam int SAMPLE_WIDTH = 16;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    localparam int S_TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int RESULT_W  = 3 * SAMPLE_WIDTH + 2;
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

>>> rtl/mme_ram.sv
// ----------------------------------------------------------------------------
// mme_ram: generic single-clock RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/median_by_min_max_elimination_unit.sv
// ----------------------------------------------------------------------------
// median_by_min_max_elimination_unit: median of a sample set
// Samples are stored in a RAM until the last one of a set; rounds of
// largest/smallest removal then leave the median, sent with max and min.
//
//  Channel   Direction  Request contents
//  s_axis    in         tdata: sample; tlast: last_sample
//  m_axis    out        tdata: median_whole, median_half, largest, smallest,
//                       overflowed
//
// Samples are taken one per cycle. The last sample of a set of N stored
// samples starts (2R+1) scan passes over the store, R = N/2 rounds for
// odd N and N/2-1 for even N, all bound by the single RAM read port; the
// result then passes through ST_WAIT_OUT to the output register.
// No input is taken during the scans or while a result waits for a free
// output register. Reset is synchronous; the RAM needs no clearing.
// ----------------------------------------------------------------------------
module median_by_min_max_elimination_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // Bits from lowest up: sample, zero padding.
    input  logic [mme_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                           i_s_axis_tlast,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // Bits from lowest up: median_whole, median_half, largest, smallest,
    // overflowed, zero padding.
    output logic [mme_pkg::M_TDATA_W-1:0]  o_m_axis_tdata
);

    import mme_pkg::*;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_WAIT_OUT
    } t_state;

    typedef enum logic [1:0] {
        PH_MAX,
        PH_MIN,
        PH_FINAL
    } t_phase;

    t_state                  r_state;
    t_phase                  r_phase;
    logic [CNT_W-1:0]        r_count;
    logic                    r_overflow;
    logic [MAX_SAMPLES-1:0]  r_marks;
    logic [SAMPLE_WIDTH-1:0] r_hi;
    logic [SAMPLE_WIDTH-1:0] r_lo;
    logic [CNT_W-1:0]        r_rounds;
    logic [CNT_W-1:0]        r_round;

    logic                    r_issue;
    logic [IDX_W-1:0]        r_rd_idx;
    logic                    r_cmp_vld;
    logic [IDX_W-1:0]        r_cmp_idx;
    logic                    r_cmp_last;

    logic                    r_found;
    logic [SAMPLE_WIDTH-1:0] r_max_val;
    logic [IDX_W-1:0]        r_max_idx;
    logic [SAMPLE_WIDTH-1:0] r_min_val;
    logic [IDX_W-1:0]        r_min_idx;

    logic                    r_out_vld;
    logic [SAMPLE_WIDTH-1:0] r_res_whole;
    logic                    r_res_half;
    logic [SAMPLE_WIDTH-1:0] r_out_whole;
    logic                    r_out_half;
    logic [SAMPLE_WIDTH-1:0] r_out_hi;
    logic [SAMPLE_WIDTH-1:0] r_out_lo;
    logic                    r_out_ovf;

    logic                    in_acc;
    logic                    store;
    logic [SAMPLE_WIDTH-1:0] sample;
    logic [CNT_W-1:0]        n_count;
    logic [CNT_W-1:0]        n_rounds;
    logic                    issue_last;
    logic [SAMPLE_WIDTH-1:0] rd_data;
    logic                    live;
    logic                    n_max_upd;
    logic                    n_min_upd;
    logic [SAMPLE_WIDTH-1:0] n_max_val;
    logic [IDX_W-1:0]        n_max_idx;
    logic [SAMPLE_WIDTH-1:0] n_min_val;
    logic [IDX_W-1:0]        n_min_idx;
    logic [SAMPLE_WIDTH:0]   n_pair;
    logic                    out_free;

    assign o_s_axis_tready = (r_state == ST_LOAD);
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign sample          = i_s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign store           = (r_count < CNT_W'(MAX_SAMPLES));
    assign n_count         = store ? r_count + CNT_W'(1) : r_count;
    assign issue_last      = (CNT_W'(r_rd_idx) == r_count - CNT_W'(1));
    assign out_free        = !r_out_vld || i_m_axis_tready;

    always_comb begin
        if (n_count < CNT_W'(2)) begin
            n_rounds = '0;
        end else if (n_count[0]) begin
            n_rounds = n_count >> 1;
        end else begin
            n_rounds = (n_count >> 1) - CNT_W'(1);
        end
    end

    mme_ram #(
        .WIDTH (SAMPLE_WIDTH),
        .DEPTH (MAX_SAMPLES),
        .AW    (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (in_acc && store),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (sample),
        .i_rd_en   (r_issue),
        .i_rd_addr (r_rd_idx),
        .o_rd_data (rd_data)
    );

    always_comb begin
        live      = !r_marks[r_cmp_idx];
        n_max_upd = live && (!r_found || rd_data > r_max_val);
        n_min_upd = live && (!r_found || rd_data < r_min_val);
        n_max_val = n_max_upd ? rd_data : r_max_val;
        n_max_idx = n_max_upd ? r_cmp_idx : r_max_idx;
        n_min_val = n_min_upd ? rd_data : r_min_val;
        n_min_idx = n_min_upd ? r_cmp_idx : r_min_idx;
        n_pair    = {1'b0, n_max_val} + {1'b0, n_min_val};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_phase    <= PH_MAX;
            r_count    <= '0;
            r_overflow <= 1'b0;
            r_marks    <= '0;
            r_round    <= '0;
            r_issue    <= 1'b0;
            r_rd_idx   <= '0;
            r_cmp_vld  <= 1'b0;
            r_cmp_last <= 1'b0;
            r_found    <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (r_out_vld && i_m_axis_tready && r_state != ST_WAIT_OUT) begin
                r_out_vld <= 1'b0;
            end

            r_cmp_vld  <= r_issue;
            r_cmp_idx  <= r_rd_idx;
            r_cmp_last <= r_issue && issue_last;
            if (r_issue) begin
                r_rd_idx <= r_rd_idx + IDX_W'(1);
                if (issue_last) begin
                    r_issue <= 1'b0;
                end
            end

            case (r_state)
                ST_LOAD: begin
                    if (in_acc) begin
                        r_count <= n_count;
                        if (store) begin
                            if (r_count == '0 || sample > r_hi) begin
                                r_hi <= sample;
                            end
                            if (r_count == '0 || sample < r_lo) begin
                                r_lo <= sample;
                            end
                        end else begin
                            r_overflow <= 1'b1;
                        end
                        if (i_s_axis_tlast) begin
                            r_state  <= ST_SCAN;
                            r_rounds <= n_rounds;
                            r_round  <= '0;
                            r_phase  <= (n_rounds == '0) ? PH_FINAL : PH_MAX;
                            r_issue  <= 1'b1;
                            r_rd_idx <= '0;
                            r_found  <= 1'b0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_cmp_vld) begin
                        r_found   <= r_cmp_last ? 1'b0 : (r_found || live);
                        r_max_val <= n_max_val;
                        r_max_idx <= n_max_idx;
                        r_min_val <= n_min_val;
                        r_min_idx <= n_min_idx;
                        if (r_cmp_last) begin
                            case (r_phase)
                                PH_MAX: begin
                                    r_issue            <= 1'b1;
                                    r_rd_idx           <= '0;
                                    r_marks[n_max_idx] <= 1'b1;
                                    r_phase            <= PH_MIN;
                                end
                                PH_MIN: begin
                                    r_issue            <= 1'b1;
                                    r_rd_idx           <= '0;
                                    r_marks[n_min_idx] <= 1'b1;
                                    r_round            <= r_round + CNT_W'(1);
                                    if (r_round + CNT_W'(1) == r_rounds) begin
                                        r_phase <= PH_FINAL;
                                    end else begin
                                        r_phase <= PH_MAX;
                                    end
                                end
                                default: begin
                                    r_res_whole <= n_pair[SAMPLE_WIDTH:1];
                                    r_res_half  <= n_pair[0];
                                    r_state     <= ST_WAIT_OUT;
                                end
                            endcase
                        end
                    end
                end
                ST_WAIT_OUT: begin
                    if (out_free) begin
                        r_out_vld   <= 1'b1;
                        r_out_whole <= r_res_whole;
                        r_out_half  <= r_res_half;
                        r_out_hi    <= r_hi;
                        r_out_lo    <= r_lo;
                        r_out_ovf   <= r_overflow;
                        r_count     <= '0;
                        r_overflow  <= 1'b0;
                        r_marks     <= '0;
                        r_state     <= ST_LOAD;
                    end
                end
                default: begin
                    r_state <= ST_LOAD;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = M_TDATA_W'({r_out_ovf, r_out_lo, r_out_hi,
                                         r_out_half, r_out_whole});

    a_marks_clear_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_LOAD |-> r_marks == '0)
        else $error("removal marks left over while loading");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SAMPLES))
        else $error("sample count beyond store depth");

    a_compare_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> r_state == ST_SCAN)
        else $error("read data compared outside a scan");

    a_survivors_in_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_phase == PH_FINAL) |->
        ($countones(r_marks) + 1 == int'(r_count) ||
         $countones(r_marks) + 2 == int'(r_count)))
        else $error("final pass does not see one or two survivors");

endmodule
